/* design/assert_macros.svh */
// Assertion helpers used by clr_datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* design/clr_pkg.sv */
package clr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int DIM_BITS_DEF   = 12;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam int COLOR_W = 32;
    localparam int PIX_W   = 12;
    localparam int KIND_W  = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // bit positions inside an outcode
    localparam int CODE_W_BIT = 0;
    localparam int CODE_E_BIT = 1;
    localparam int CODE_N_BIT = 2;
    localparam int CODE_S_BIT = 3;

    typedef struct packed {
        logic load;
        logic code;
        logic step;
        logic mul;
        logic div;
        logic apply;
        logic setup;
        logic reject;
        logic pt;
        logic horz;
    } clr_cmd_t;

    typedef struct packed {
        logic share;
        logic pt_clear;
        logic pt_vert;
        logic pt_horz;
        logic x_out;
        logic pt_in;
        logic div_done;
        logic out_busy;
    } clr_stat_t;

endpackage

/* design/clr_in_if.sv */
interface clr_in_if #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic signed [COORD_BITS-1:0]       start_x;
    logic signed [COORD_BITS-1:0]       start_y;
    logic signed [COORD_BITS-1:0]       end_x;
    logic signed [COORD_BITS-1:0]       end_y;
    logic [clr_pkg::COLOR_W-1:0]        line_color;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink (input valid, cmd, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

/* design/clr_out_if.sv */
interface clr_out_if;
    logic                           valid;
    logic                           ready;
    logic [clr_pkg::KIND_W-1:0]     kind;
    logic [clr_pkg::PIX_W-1:0]      pixel_x;
    logic [clr_pkg::PIX_W-1:0]      pixel_y;
    logic [clr_pkg::COLOR_W-1:0]    pixel_color;
    logic                           last;

    modport source (output valid, kind, pixel_x, pixel_y, pixel_color, last,
                    input ready);
    modport sink (input valid, kind, pixel_x, pixel_y, pixel_color, last,
                  output ready);
endinterface

/* design/clr_ctrl.sv */
module clr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  clr_pkg::clr_stat_t  stat,
    output clr_pkg::clr_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CODE  = 4'd1;
    localparam logic [3:0] S_SEL   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_APPLY = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_SETUP = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       pt_reg, pt_next;
    logic       horz_reg, horz_next;

    always_comb
    begin
        state_next = state_reg;
        pt_next    = pt_reg;
        horz_next  = horz_reg;
        cmd        = '0;
        cmd.pt     = pt_reg;
        cmd.horz   = horz_reg;
        in_ready   = (state_reg == S_IDLE) && !stat.out_busy;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_cmd == clr_pkg::CMD_STEP)
                    begin
                        cmd.step = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        pt_next    = 1'b0;
                        state_next = S_CODE;
                    end
                end
            end
            S_CODE:
            begin
                cmd.code   = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                if (!pt_reg && stat.share)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.pt_clear)
                begin
                    if (pt_reg)
                        state_next = S_SETUP;
                    else
                        pt_next = 1'b1;
                end
                else
                begin
                    // corner regions try the top or bottom edge first
                    horz_next  = !stat.pt_vert;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_APPLY;
                else
                    cmd.div = 1'b1;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!horz_reg && stat.pt_horz && stat.x_out)
                begin
                    horz_next  = 1'b1;
                    state_next = S_MUL;
                end
                else if (!stat.pt_in)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!pt_reg)
                begin
                    pt_next    = 1'b1;
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pt_reg    <= 1'b0;
            horz_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
            horz_reg  <= horz_next;
        end
    end

endmodule

/* design/clr_datapath.sv */
`include "assert_macros.svh"

module clr_datapath #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF,
    parameter int DIM_BITS   = clr_pkg::DIM_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  clr_pkg::clr_cmd_t               cmd,
    output clr_pkg::clr_stat_t              stat,
    input  logic signed [COORD_BITS-1:0]    start_x,
    input  logic signed [COORD_BITS-1:0]    start_y,
    input  logic signed [COORD_BITS-1:0]    end_x,
    input  logic signed [COORD_BITS-1:0]    end_y,
    input  logic [clr_pkg::COLOR_W-1:0]     line_color,
    input  logic [clr_pkg::CFG_W-1:0]       frame_width,
    input  logic [clr_pkg::CFG_W-1:0]       frame_height,
    clr_out_if.source                       out_ch
);

    localparam int EW   = (COORD_BITS > DIM_BITS) ? COORD_BITS + 2 : DIM_BITS + 2;
    localparam int DDW  = COORD_BITS + 1;
    localparam int NW   = EW + 1;
    localparam int PWID = NW + DDW;
    localparam int CNTW = $clog2(PWID + 1);
    localparam int DW   = DIM_BITS;
    localparam int EEW  = DIM_BITS + 3;

    function automatic logic [3:0] outcode(input logic signed [EW-1:0] x,
                                           input logic signed [EW-1:0] y,
                                           input logic signed [EW-1:0] w,
                                           input logic signed [EW-1:0] h);
        logic [3:0] c;
        c = '0;
        if (x < 0)
            c[clr_pkg::CODE_W_BIT] = 1'b1;
        else if (x >= w)
            c[clr_pkg::CODE_E_BIT] = 1'b1;
        if (y < 0)
            c[clr_pkg::CODE_N_BIT] = 1'b1;
        else if (y >= h)
            c[clr_pkg::CODE_S_BIT] = 1'b1;
        return c;
    endfunction

    // clipping registers
    logic signed [EW-1:0]   x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [DDW-1:0]  ddx_reg, ddy_reg;
    logic [clr_pkg::COLOR_W-1:0] ld_color_reg;
    logic [3:0]             c0_reg, c1_reg;
    logic [PWID-1:0]        mag_reg;
    logic [DDW-1:0]         den_reg;
    logic [DDW-1:0]         rem_reg;
    logic                   neg_reg, zden_reg;
    logic signed [EW-1:0]   edge_reg;
    logic [CNTW-1:0]        cnt_reg;

    // line walk registers
    logic                   active_reg;
    logic [DW-1:0]          cur_x_reg, cur_y_reg;
    logic signed [EEW-1:0]  err_reg;
    logic [DW-1:0]          major_reg, minor_reg, steps_reg;
    logic                   sxn_reg, syn_reg, xmaj_reg;
    logic [clr_pkg::COLOR_W-1:0] color_reg;

    // output register
    logic                   ov_reg;
    logic [clr_pkg::KIND_W-1:0]  kind_reg;
    logic [clr_pkg::PIX_W-1:0]   px_reg, py_reg;
    logic [clr_pkg::COLOR_W-1:0] pcol_reg;
    logic                   last_reg;

    logic [EW-1:0]          lim, wext, hext;
    logic signed [EW-1:0]   w_dim, h_dim;
    logic signed [EW-1:0]   p_x, p_y, r_x, r_y;
    logic [3:0]             p_code;
    logic signed [EW-1:0]   edge_v;
    logic signed [NW-1:0]   num;
    logic signed [DDW-1:0]  fac, den;
    logic signed [PWID-1:0] prod;
    logic [DDW:0]           trial;
    logic                   ge;
    logic [EW-1:0]          qm;
    logic signed [EW-1:0]   q, sum;
    logic signed [EW-1:0]   dx, dy, adx_f, ady_f;
    logic [DW-1:0]          adx, ady, maj_n, min_n;
    logic                   xmaj_n;
    logic signed [EEW-1:0]  err_mid, err_new;
    logic                   out_wr;

    assign lim   = EW'(1) << DW;
    assign wext  = EW'(frame_width);
    assign hext  = EW'(frame_height);
    assign w_dim = $signed((wext > lim) ? lim : wext);
    assign h_dim = $signed((hext > lim) ? lim : hext);

    assign p_x    = cmd.pt ? x1_reg : x0_reg;
    assign p_y    = cmd.pt ? y1_reg : y0_reg;
    assign r_x    = cmd.pt ? x0_reg : x1_reg;
    assign r_y    = cmd.pt ? y0_reg : y1_reg;
    assign p_code = cmd.pt ? c1_reg : c0_reg;

    always_comb
    begin
        if (cmd.horz)
        begin
            edge_v = p_code[clr_pkg::CODE_W_BIT] ? '0 : w_dim - EW'(1);
            num    = NW'(edge_v) - NW'(r_x);
            fac    = ddy_reg;
            den    = ddx_reg;
        end
        else
        begin
            edge_v = p_code[clr_pkg::CODE_N_BIT] ? '0 : h_dim - EW'(1);
            num    = NW'(edge_v) - NW'(r_y);
            fac    = ddx_reg;
            den    = ddy_reg;
        end
    end

    assign prod  = num * fac;
    assign trial = {rem_reg, mag_reg[PWID-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // quotient is bounded by the coordinate delta, so its low bits carry it
    assign qm  = mag_reg[EW-1:0];
    assign q   = zden_reg ? '0 : (neg_reg ? -$signed(qm) : $signed(qm));
    assign sum = (cmd.horz ? r_y : r_x) + q;

    assign dx    = x1_reg - x0_reg;
    assign dy    = y1_reg - y0_reg;
    assign adx_f = dx[EW-1] ? -dx : dx;
    assign ady_f = dy[EW-1] ? -dy : dy;
    assign adx   = adx_f[DW-1:0];
    assign ady   = ady_f[DW-1:0];
    assign xmaj_n = adx >= ady;
    assign maj_n  = xmaj_n ? adx : ady;
    assign min_n  = xmaj_n ? ady : adx;

    assign err_mid = (err_reg > 0) ? err_reg - $signed({2'b00, major_reg, 1'b0}) : err_reg;
    assign err_new = err_mid + $signed({2'b00, minor_reg, 1'b0});

    assign out_wr = cmd.step || cmd.setup || cmd.reject;

    assign stat.share    = (c0_reg & c1_reg) != 4'd0;
    assign stat.pt_clear = p_code == 4'd0;
    assign stat.pt_vert  = p_code[clr_pkg::CODE_N_BIT] || p_code[clr_pkg::CODE_S_BIT];
    assign stat.pt_horz  = p_code[clr_pkg::CODE_W_BIT] || p_code[clr_pkg::CODE_E_BIT];
    assign stat.x_out    = (p_x < 0) || (p_x >= w_dim);
    assign stat.pt_in    = outcode(p_x, p_y, w_dim, h_dim) == 4'd0;
    assign stat.div_done = cnt_reg == '0;
    assign stat.out_busy = ov_reg && !out_ch.ready;

    // clipping datapath
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x0_reg       <= EW'(start_x);
            y0_reg       <= EW'(start_y);
            x1_reg       <= EW'(end_x);
            y1_reg       <= EW'(end_y);
            ddx_reg      <= DDW'(end_x) - DDW'(start_x);
            ddy_reg      <= DDW'(end_y) - DDW'(start_y);
            ld_color_reg <= line_color;
        end
        if (cmd.code)
        begin
            c0_reg <= outcode(x0_reg, y0_reg, w_dim, h_dim);
            c1_reg <= outcode(x1_reg, y1_reg, w_dim, h_dim);
        end
        if (cmd.mul)
        begin
            mag_reg  <= prod[PWID-1] ? PWID'(-prod) : PWID'(prod);
            den_reg  <= den[DDW-1] ? DDW'(-den) : DDW'(den);
            neg_reg  <= prod[PWID-1] ^ den[DDW-1];
            zden_reg <= den == '0;
            edge_reg <= edge_v;
            rem_reg  <= '0;
        end
        else if (cmd.div)
        begin
            rem_reg <= ge ? DDW'(trial - {1'b0, den_reg}) : trial[DDW-1:0];
            mag_reg <= {mag_reg[PWID-2:0], ge};
        end
        if (cmd.apply)
        begin
            if (cmd.horz)
            begin
                if (cmd.pt)
                begin
                    x1_reg <= edge_reg;
                    y1_reg <= sum;
                end
                else
                begin
                    x0_reg <= edge_reg;
                    y0_reg <= sum;
                end
            end
            else
            begin
                if (cmd.pt)
                begin
                    x1_reg <= sum;
                    y1_reg <= edge_reg;
                end
                else
                begin
                    x0_reg <= sum;
                    y0_reg <= edge_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.mul)
            cnt_reg <= CNTW'(PWID);
        else if (cmd.div)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // line walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            err_reg    <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            steps_reg  <= '0;
            sxn_reg    <= 1'b0;
            syn_reg    <= 1'b0;
            xmaj_reg   <= 1'b0;
            color_reg  <= '0;
        end
        else if (cmd.load || cmd.reject)
        begin
            active_reg <= 1'b0;
        end
        else if (cmd.setup)
        begin
            sxn_reg    <= !((dx > 0));
            syn_reg    <= !((dy > 0));
            xmaj_reg   <= xmaj_n;
            major_reg  <= maj_n;
            minor_reg  <= min_n;
            steps_reg  <= maj_n;
            err_reg    <= $signed({2'b00, min_n, 1'b0}) - $signed({3'b000, maj_n});
            cur_x_reg  <= x0_reg[DW-1:0];
            cur_y_reg  <= y0_reg[DW-1:0];
            color_reg  <= ld_color_reg;
            active_reg <= maj_n != '0;
        end
        else if (cmd.step && active_reg)
        begin
            steps_reg <= steps_reg - 1'b1;
            if (steps_reg == DW'(1))
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                err_reg <= err_new;
                if (xmaj_reg || err_reg > 0)
                    cur_x_reg <= sxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                if (!xmaj_reg || err_reg > 0)
                    cur_y_reg <= syn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_wr)
            ov_reg <= 1'b1;
        else if (out_ch.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            pcol_reg <= '0;
            last_reg <= 1'b0;
            if (cmd.reject)
                kind_reg <= clr_pkg::KIND_REJECT;
            else if (cmd.setup)
                kind_reg <= clr_pkg::KIND_ACCEPT;
            else if (!active_reg)
                kind_reg <= clr_pkg::KIND_NONE;
            else
            begin
                kind_reg <= clr_pkg::KIND_PIXEL;
                px_reg   <= clr_pkg::PIX_W'(cur_x_reg);
                py_reg   <= clr_pkg::PIX_W'(cur_y_reg);
                pcol_reg <= color_reg;
                last_reg <= steps_reg == DW'(1);
            end
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.kind        = kind_reg;
    assign out_ch.pixel_x     = px_reg;
    assign out_ch.pixel_y     = py_reg;
    assign out_ch.pixel_color = pcol_reg;
    assign out_ch.last        = last_reg;

    `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, out_wr, !stat.out_busy, "result overwritten")
    `ASSERT_IMPLY(a_active_steps, clk, rst_n, active_reg, steps_reg != '0, "active line with no steps")
    `ASSERT_IMPLY(a_major_ge_minor, clk, rst_n, active_reg, major_reg >= minor_reg, "bad deltas")
    `ASSERT_NEXT(a_last_clears, clk, rst_n, cmd.step && active_reg && steps_reg == DW'(1), !active_reg, "line left active after last")

endmodule

/* design/clipped_line_rasterizer_core.sv */
// Clipped line rasterizer. A load transfer (cmd 0) clips the two signed endpoints
// against the frame_width by frame_height frame and answers accepted or rejected;
// each step transfer (cmd 1) answers the next pixel of the line, the second
// endpoint excluded and the final pixel marked by last, or "no line active".
// A load codes both endpoints and then, for every edge an endpoint is moved to
// (at most two per endpoint), multiplies and runs the shared bit-serial restoring
// divider over a P-bit product, P = max(COORD_BITS, DIM_BITS) + COORD_BITS + 4
// (36 at the default widths). Results sit in an output register; a new transfer is
// taken once the previous result has left or is leaving. The user must write frame
// registers via cfg_we/cfg_index/cfg_data while the block is idle (not enforced).
module clipped_line_rasterizer_core #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF,
    parameter int DIM_BITS   = clr_pkg::DIM_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    clr_in_if.sink                          in_ch,
    clr_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clr_pkg::CFG_W-1:0]       cfg_data
);

    logic [clr_pkg::CFG_W-1:0] width_reg, height_reg;
    clr_pkg::clr_cmd_t  cmd;
    clr_pkg::clr_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clr_pkg::FRAME_WIDTH_RST;
            height_reg <= clr_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                clr_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                clr_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    clr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clr_datapath #(
        .COORD_BITS (COORD_BITS),
        .DIM_BITS   (DIM_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .start_x      (in_ch.start_x),
        .start_y      (in_ch.start_y),
        .end_x        (in_ch.end_x),
        .end_y        (in_ch.end_y),
        .line_color   (in_ch.line_color),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .out_ch       (out_ch)
    );

endmodule
